FILE: sv/cbb_pkg.sv
package cbb_pkg;

  // Ring geometry and item field widths
  localparam int DEPTH    = 1024;
  localparam int MAX_PEEK = 64;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int CNT_W    = 10;
  localparam int BYTE_W   = 8;
  // wide enough for pointer plus offset without overflow
  localparam int SUM_W    = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_PEEK = 2'd1,
    OP_POP  = 2'd2,
    OP_READ = 2'd3
  } cbb_op_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic emit;     // load output register from store read data
  } cbb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic imm_result;  // the offered item yields its result at acceptance
    logic start_mem;   // the offered item needs store reads (peek / indexed read)
    logic last_mem;    // the byte now held in read data is the final one
  } cbb_stat_t;

endpackage

FILE: sv/cbb_ctrl.sv
module cbb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cbb_pkg::cbb_stat_t  stat,
  output cbb_pkg::cbb_cmd_t   cmd
);
  import cbb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_MEM  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // output register can take a new beat
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign out_valid = out_valid_r;

  assign cmd.accept = in_valid && in_ready;
  assign cmd.emit   = (state_r == S_MEM) && slot_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && stat.start_mem) state_nxt = S_MEM;
      end
      S_MEM: begin
        if (cmd.emit && stat.last_mem) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid: loaded on an immediate result or a store byte
  assign out_valid_nxt = (out_valid_r && !out_ready) ||
                         (cmd.accept && stat.imm_result) || cmd.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_start_mem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && stat.start_mem |=> state_r == S_MEM && !out_valid_r)
    else $error("read sequence start left a stale output beat");

  a_mem_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && stat.last_mem |=> state_r == S_IDLE && out_valid_r)
    else $error("final store byte did not return to idle");

  a_imm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && stat.imm_result |=> out_valid_r && state_r == S_IDLE)
    else $error("immediate result not presented");

endmodule

FILE: sv/cbb_datapath.sv
module cbb_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_operation,
  input  logic [cbb_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [cbb_pkg::CNT_W-1:0]     in_count,
  input  logic [cbb_pkg::CNT_W-1:0]     in_index,
  input  cbb_pkg::cbb_cmd_t             cmd,
  output cbb_pkg::cbb_stat_t            stat,
  output logic [cbb_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                          out_ok,
  output logic                          out_last,
  output logic [cbb_pkg::CNT_W-1:0]     out_fill_level,
  output logic [cbb_pkg::CNT_W-1:0]     out_free_space
);
  import cbb_pkg::*;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  // (a + b) mod DEPTH, with a < DEPTH and b < DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + b;
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  // bytes held between head and tail
  function automatic logic [PTR_W-1:0] held_of(input logic [PTR_W-1:0] head,
                                                input logic [PTR_W-1:0] tail);
    logic [PTR_W:0] d;
    d = {1'b0, tail} - {1'b0, head};
    if (tail < head) d = d + (PTR_W+1)'(DEPTH);
    return d[PTR_W-1:0];
  endfunction

  // byte store, one write and one registered read port
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  logic [PTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  push_offset_r, push_offset_nxt;
  logic [CNT_W-1:0]  block_length_r, block_length_nxt;
  logic              block_active_r, block_active_nxt;
  logic              block_acc_r, block_acc_nxt;
  logic [CNT_W-1:0]  offset_r, offset_acc, offset_sel;
  logic [CNT_W:0]    end_r, end_acc;

  logic [PTR_W-1:0]  held_cur, held_new, rd_addr, wr_addr;
  cbb_op_t           op;
  logic              first, acc, push_done, mem_we, imm_ok;
  logic              cnt_gt_held, idx_ge_held;
  logic [CNT_W-1:0]  len, off, off1;

  assign op       = cbb_op_t'(in_operation);
  assign held_cur = held_of(head_r, tail_r);

  assign cnt_gt_held = SUM_W'(in_count) > SUM_W'(held_cur);
  assign idx_ge_held = SUM_W'(in_index) >= SUM_W'(held_cur);

  // push block bookkeeping for the offered beat
  assign first     = !block_active_r;
  assign len       = first ? in_count : block_length_r;
  assign acc       = first ? (SUM_W'(in_count) <= SUM_W'(LAST_SLOT - held_cur))
                           : block_acc_r;
  assign off       = first ? '0 : push_offset_r;
  assign off1      = off + CNT_W'(1);
  assign push_done = off1 >= len;
  assign wr_addr   = wrap_add(tail_r, SUM_W'(off));

  // effect of the offered item if it is accepted
  always_comb begin
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    push_offset_nxt  = push_offset_r;
    block_length_nxt = block_length_r;
    block_active_nxt = block_active_r;
    block_acc_nxt    = block_acc_r;
    offset_acc       = offset_r;
    end_acc          = end_r;
    mem_we           = 1'b0;
    imm_ok           = 1'b0;
    stat.imm_result  = 1'b0;
    stat.start_mem   = 1'b0;
    // byte now in read data closes the read sequence
    stat.last_mem    = ({1'b0, offset_r} + (CNT_W+1)'(1)) == end_r;
    // any non-push item drops an open block
    if (op != OP_PUSH) begin
      block_active_nxt = 1'b0;
      push_offset_nxt  = '0;
    end
    unique case (op)
      OP_PUSH: begin
        if (first && in_count == '0) begin
          stat.imm_result = 1'b1;
          imm_ok          = 1'b1;
        end else begin
          mem_we = acc;
          if (push_done) begin
            stat.imm_result  = 1'b1;
            imm_ok           = acc;
            if (acc) tail_nxt = wrap_add(tail_r, SUM_W'(len));
            block_active_nxt = 1'b0;
            push_offset_nxt  = '0;
          end else begin
            block_active_nxt = 1'b1;
            block_length_nxt = len;
            block_acc_nxt    = acc;
            push_offset_nxt  = off1;
          end
        end
      end
      OP_PEEK: begin
        if (cnt_gt_held) begin
          stat.imm_result = 1'b1;
        end else if (in_count == '0) begin
          stat.imm_result = 1'b1;
          imm_ok          = 1'b1;
        end else begin
          stat.start_mem = 1'b1;
          offset_acc     = '0;
          end_acc        = (in_count > CNT_W'(MAX_PEEK)) ? (CNT_W+1)'(MAX_PEEK)
                                                         : {1'b0, in_count};
        end
      end
      OP_POP: begin
        stat.imm_result = 1'b1;
        if (!cnt_gt_held) begin
          imm_ok   = 1'b1;
          head_nxt = wrap_add(head_r, SUM_W'(in_count));
        end
      end
      OP_READ: begin
        if (idx_ge_held) begin
          stat.imm_result = 1'b1;
        end else begin
          stat.start_mem = 1'b1;
          offset_acc     = in_index;
          end_acc        = {1'b0, in_index} + (CNT_W+1)'(1);
        end
      end
    endcase
  end

  assign held_new      = held_of(head_nxt, tail_nxt);

  // read address follows the offset's next value, so read data tracks offset_r
  always_comb begin
    priority if (cmd.accept) offset_sel = offset_acc;
    else if (cmd.emit)       offset_sel = offset_r + CNT_W'(1);
    else                     offset_sel = offset_r;
  end
  assign rd_addr = wrap_add(head_r, SUM_W'(offset_sel));

  // store write / read
  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) mem[wr_addr] <= in_data_byte;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // pointers and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r         <= '0;
      tail_r         <= '0;
      push_offset_r  <= '0;
      block_active_r <= 1'b0;
      block_acc_r    <= 1'b0;
    end else if (cmd.accept) begin
      head_r         <= head_nxt;
      tail_r         <= tail_nxt;
      push_offset_r  <= push_offset_nxt;
      block_active_r <= block_active_nxt;
      block_acc_r    <= block_acc_nxt;
    end
  end

  // read sequence counters and block length
  always_ff @(posedge clk) begin
    offset_r <= offset_sel;
    if (cmd.accept) begin
      end_r          <= end_acc;
      block_length_r <= block_length_nxt;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.accept && stat.imm_result) begin
      out_read_byte  <= '0;
      out_ok         <= imm_ok;
      out_last       <= 1'b1;
      out_fill_level <= CNT_W'(held_new);
      out_free_space <= CNT_W'(LAST_SLOT - held_new);
    end else if (cmd.emit) begin
      out_read_byte  <= rd_data_r;
      out_ok         <= 1'b1;
      out_last       <= stat.last_mem;
      out_fill_level <= CNT_W'(held_cur);
      out_free_space <= CNT_W'(LAST_SLOT - held_cur);
    end
  end

  a_block_off: assert property (@(posedge clk) disable iff (!rst_n)
    block_active_r |-> push_offset_r < block_length_r && push_offset_r != '0)
    else $error("open block offset out of range");

  a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
    !block_active_r |-> push_offset_r == '0)
    else $error("push offset not cleared without open block");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> {1'b0, offset_r} < end_r)
    else $error("store byte emitted past sequence end");

endmodule

FILE: sv/circular_byte_buffer_unit.sv
// Byte ring buffer with command-driven push, peek, pop and indexed read.
// Input channel (in_valid/in_ready): one beat per byte of a pushed block
// (first beat carries the block length in in_count), or one beat per peek,
// pop or indexed read command. Result channel (out_valid/out_ready): every
// result beat carries ok, last, fill level and free space.
// A push that closes a block, a pop, a zero-count peek or any refused
// command gives its beat in the cycle after acceptance, from the output
// register. Peek and indexed read pass the store's registered read port,
// then the output register. Store bytes, and push and pop items, go one
// per cycle unless the receiver stalls; a peek (at most 64 bytes) or an
// indexed read holds the input until its last byte is emitted.
// A stalled receiver holds the output register; new items are taken only
// when that register is free or being emptied in the same cycle.
// Reset (synchronous, rst_n low) empties the ring: head, tail and block
// state clear at once. Store contents are not cleared and need no sweep.
module circular_byte_buffer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [cbb_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic [cbb_pkg::CNT_W-1:0]     in_count,
  input  logic [cbb_pkg::CNT_W-1:0]     in_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbb_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                          out_ok,
  output logic                          out_last,
  output logic [cbb_pkg::CNT_W-1:0]     out_fill_level,
  output logic [cbb_pkg::CNT_W-1:0]     out_free_space
);
  import cbb_pkg::*;

  cbb_cmd_t  cmd;
  cbb_stat_t stat;

  cbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cbb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .in_count       (in_count),
    .in_index       (in_index),
    .cmd            (cmd),
    .stat           (stat),
    .out_read_byte  (out_read_byte),
    .out_ok         (out_ok),
    .out_last       (out_last),
    .out_fill_level (out_fill_level),
    .out_free_space (out_free_space)
  );

endmodule
